@@ src/mhft_pkg.sv @@
// mhft_pkg: shared types, codes and the key hash for the flow match table.
// Used by multi_hash_flow_match_table and its port checker.
`default_nettype none

package mhft_pkg;

    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int PAY_W       = 32;
    localparam int SLOT_W      = 12;
    localparam int SEED_W      = 12;
    localparam int SEED_NUM    = 4;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;
    localparam int CFG_AW      = 4;
    localparam int CFG_DW      = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 48;

    localparam logic [31:0] SCRAMBLER_RESET = 32'd19260817;
    localparam int          PROBE_STEP      = 133;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_RSVD   = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISS     = 2'd3
    } t_status;

    // seeded shift-xor hash, 32-bit wrap; caller masks to pool size
    function automatic logic [31:0] key_hash(input logic [SEED_W-1:0] seed,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [PORT_W-1:0] port);
        logic [31:0] h;
        h = 32'(seed);
        h = (h << 2) ^ h ^ addr;
        h = (h << 2) ^ h ^ 32'(port);
        return h;
    endfunction

endpackage

`default_nettype wire

@@ src/mhft_ram.sv @@
// mhft_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mhft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/multi_hash_flow_match_table.sv @@
// Flow match table: HASH_COUNT hashed index tables point into a pool of slots.
// An unused request code goes straight to the output state; the rest hash each table in
// turn, then an insert scrambles a start slot and probes for a free one, and a search or
// removal votes over the tables, then reads the winning slot unless no entry votes. Input
// reopens as the result loads; a stalled result holds the sequencer in its output state.
// One hash unit, one vote step. Reset (sync, active low) clears control, seeds and
// scrambler, then a clearing pass empties slot-valid and index RAMs before input opens.
`default_nettype none

module multi_hash_flow_match_table #(
    parameter int POOL_SIZE   = 4096,
    parameter int HASH_COUNT  = 4,
    parameter int PROBE_LIMIT = 1000
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata: key_addr[31:0], key_port[47:32], entry_payload[79:48]
    input  wire logic [mhft_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: req_type[1:0]
    input  wire logic [mhft_pkg::REQ_W-1:0]       i_s_tuser,
    // result stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // tdata: slot_index[11:0], found_payload[43:12], zero fill
    output logic      [mhft_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // tuser: status[1:0]
    output logic      [mhft_pkg::STAT_W-1:0]      o_m_tuser,
    // APB configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mhft_pkg::CFG_AW-1:0]      paddr,
    input  wire logic [mhft_pkg::CFG_DW-1:0]      pwdata,
    output logic      [mhft_pkg::CFG_DW-1:0]      prdata,
    output logic                                  pready
);

    import mhft_pkg::*;

    localparam int PW  = $clog2(POOL_SIZE);            // slot number width
    localparam int EW  = PW + 1;                       // index entry: {used, slot}
    localparam int TCW = $clog2(HASH_COUNT + 1);       // table counter
    localparam int HIW = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
    localparam int VW  = $clog2(HASH_COUNT + 1);       // vote count
    localparam int KW  = $clog2(PROBE_LIMIT + 1);      // probe counter

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_SCRAM, S_PRB_RD, S_PRB_CHK, S_INS_WR,
        S_TAB_RD, S_VOTE, S_VOTE_END, S_SLOT_RD, S_SLOT_CHK, S_OUT
    } t_state;

    t_state               r_state;
    logic                 r_clr_busy;
    logic [PW-1:0]        r_clr;
    logic [REQ_W-1:0]     r_req;
    logic [ADDR_W-1:0]    r_addr;
    logic [PORT_W-1:0]    r_port;
    logic [PAY_W-1:0]     r_pay;
    logic [PW-1:0]        r_hash [HASH_COUNT];
    logic [TCW-1:0]       r_t;
    logic [31:0]          r_scr;
    logic [PW-1:0]        r_pos;
    logic [KW-1:0]        r_k;
    logic                 r_have;
    logic [PW-1:0]        r_cand;
    logic [VW-1:0]        r_votes;
    logic [STAT_W-1:0]    r_res_st;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [PAY_W-1:0]     r_res_pay;
    logic                 r_ovalid;
    logic [STAT_W-1:0]    r_ost;
    logic [SLOT_W-1:0]    r_oslot;
    logic [PAY_W-1:0]     r_opay;
    logic [SEED_W-1:0]    r_seed [SEED_NUM];

    logic [31:0]          n_scr;
    logic [EW-1:0]        tab_rd [HASH_COUNT];
    logic [EW-1:0]        vote_ent;
    logic                 slot_vld_rd;
    logic [PAY_W-1:0]     slot_pay_rd;
    logic                 vld_we;
    logic [PW-1:0]        vld_waddr;
    logic                 vld_wdata;
    logic                 pay_we;
    logic                 cfg_wr;
    logic                 out_free;

    // ---------------- configuration ----------------
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = CFG_DW'(r_seed[paddr[3:2]]);

    // ---------------- slot pool ----------------
    always_comb begin
        vld_we    = 1'b0;
        vld_waddr = r_pos;
        vld_wdata = 1'b0;
        if (r_clr_busy) begin
            vld_we    = 1'b1;
            vld_waddr = r_clr;
        end else if (r_state == S_INS_WR) begin
            vld_we    = 1'b1;
            vld_wdata = 1'b1;
        end else if (r_state == S_SLOT_CHK && r_req == REQ_REMOVE) begin
            vld_we    = 1'b1;
        end
    end

    assign pay_we = (r_state == S_INS_WR);

    mhft_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_slot_vld (
        .i_clk   (i_clk),
        .i_we    (vld_we),
        .i_waddr (vld_waddr),
        .i_wdata (vld_wdata),
        .i_raddr (r_pos),
        .o_rdata (slot_vld_rd)
    );

    mhft_ram #(.WIDTH(PAY_W), .DEPTH(POOL_SIZE)) u_slot_pay (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (r_pos),
        .i_wdata (r_pay),
        .i_raddr (r_pos),
        .o_rdata (slot_pay_rd)
    );

    // ---------------- index tables, one RAM per hash ----------------
    // Read address is the key's hash, held stable for the whole search,
    // so the read data stays valid through vote and removal.
    for (genvar g = 0; g < HASH_COUNT; g++) begin : g_tab
        logic          tab_we;
        logic [PW-1:0] tab_waddr;
        logic [EW-1:0] tab_wdata;

        always_comb begin
            tab_we    = 1'b0;
            tab_waddr = r_hash[g];
            tab_wdata = '0;
            if (r_clr_busy) begin
                tab_we    = 1'b1;
                tab_waddr = r_clr;
            end else if (r_state == S_INS_WR) begin
                tab_we    = 1'b1;
                tab_wdata = {1'b1, r_pos};
            end else if (r_state == S_SLOT_CHK && r_req == REQ_REMOVE) begin
                tab_we    = tab_rd[g][PW] && (tab_rd[g][PW-1:0] == r_cand);
            end
        end

        mhft_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_tab (
            .i_clk   (i_clk),
            .i_we    (tab_we),
            .i_waddr (tab_waddr),
            .i_wdata (tab_wdata),
            .i_raddr (r_hash[g]),
            .o_rdata (tab_rd[g])
        );
    end

    assign n_scr    = (r_scr << 2) ^ r_scr ^ 32'd1;
    assign vote_ent = tab_rd[r_t[HIW-1:0]];
    assign out_free = !r_ovalid || i_m_tready;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr_busy <= 1'b1;
            r_clr      <= '0;
            r_t        <= '0;
            r_scr      <= SCRAMBLER_RESET;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < SEED_NUM; i++) begin
                r_seed[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                r_seed[paddr[3:2]] <= pwdata[SEED_W-1:0];
            end
            if (r_clr_busy) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == PW'(POOL_SIZE - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            // output state reloads the register itself when it drains
            if (r_ovalid && i_m_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && !r_clr_busy) begin
                        r_req  <= i_s_tuser;
                        r_addr <= i_s_tdata[31:0];
                        r_port <= i_s_tdata[47:32];
                        r_pay  <= i_s_tdata[79:48];
                        r_t    <= '0;
                        if (i_s_tuser inside {REQ_INSERT, REQ_SEARCH, REQ_REMOVE}) begin
                            r_state <= S_HASH;
                        end else begin
                            r_res_st   <= ST_MISS;
                            r_res_slot <= '0;
                            r_res_pay  <= '0;
                            r_state    <= S_OUT;
                        end
                    end
                end
                S_HASH: begin
                    // shared hash unit, one table per cycle
                    r_hash[r_t[HIW-1:0]] <= PW'(key_hash(r_seed[2'(r_t)], r_addr, r_port));
                    if (r_t == TCW'(HASH_COUNT - 1)) begin
                        r_t     <= '0;
                        r_state <= (r_req == REQ_INSERT) ? S_SCRAM : S_TAB_RD;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                S_SCRAM: begin
                    r_scr   <= n_scr;
                    r_pos   <= r_hash[0] ^ PW'(n_scr);
                    r_k     <= '0;
                    r_state <= S_PRB_RD;
                end
                S_PRB_RD: begin
                    r_state <= S_PRB_CHK;
                end
                S_PRB_CHK: begin
                    if (!slot_vld_rd) begin
                        r_state <= S_INS_WR;
                    end else if (r_k == KW'(PROBE_LIMIT)) begin
                        r_res_st   <= ST_FULL;
                        r_res_slot <= '0;
                        r_res_pay  <= '0;
                        r_state    <= S_OUT;
                    end else begin
                        r_pos   <= r_pos + PW'(PROBE_STEP);
                        r_k     <= r_k + 1'b1;
                        r_state <= S_PRB_RD;
                    end
                end
                S_INS_WR: begin
                    r_res_st   <= ST_INSERTED;
                    r_res_slot <= SLOT_W'(r_pos);
                    r_res_pay  <= '0;
                    r_state    <= S_OUT;
                end
                S_TAB_RD: begin
                    r_have  <= 1'b0;
                    r_cand  <= '0;
                    r_votes <= '0;
                    r_state <= S_VOTE;
                end
                S_VOTE: begin
                    // majority vote, one table entry per cycle
                    if (vote_ent[PW]) begin
                        if (r_have && vote_ent[PW-1:0] == r_cand) begin
                            r_votes <= r_votes + 1'b1;
                        end else if (r_votes == '0) begin
                            r_votes <= VW'(1);
                            r_cand  <= vote_ent[PW-1:0];
                            r_have  <= 1'b1;
                        end else begin
                            r_votes <= r_votes - 1'b1;
                        end
                    end
                    if (r_t == TCW'(HASH_COUNT - 1)) begin
                        r_state <= S_VOTE_END;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                S_VOTE_END: begin
                    if (!r_have) begin
                        r_res_st   <= ST_MISS;
                        r_res_slot <= '0;
                        r_res_pay  <= '0;
                        r_state    <= S_OUT;
                    end else begin
                        r_pos   <= r_cand;
                        r_state <= S_SLOT_RD;
                    end
                end
                S_SLOT_RD: begin
                    r_state <= S_SLOT_CHK;
                end
                S_SLOT_CHK: begin
                    // removal writes happen this cycle (see RAM write muxes)
                    if (slot_vld_rd) begin
                        r_res_st   <= ST_FOUND;
                        r_res_slot <= SLOT_W'(r_cand);
                        r_res_pay  <= slot_pay_rd;
                    end else begin
                        r_res_st   <= ST_MISS;
                        r_res_slot <= '0;
                        r_res_pay  <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ost    <= r_res_st;
                        r_oslot  <= r_res_slot;
                        r_opay   <= r_res_pay;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ost;
    assign o_m_tdata  = {{(OUT_TDATA_W - SLOT_W - PAY_W){1'b0}}, r_opay, r_oslot};

endmodule

`default_nettype wire

@@ src/mhft_chk.sv @@
// mhft_chk: port-level checks for multi_hash_flow_match_table, plus its bind.
// Depends on mhft_pkg for status codes.
`default_nettype none

module mhft_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_tvalid,
    input wire logic                             o_s_tready,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [mhft_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic [mhft_pkg::STAT_W-1:0]      o_m_tuser
);

    import mhft_pkg::*;

    // one transaction in flight: input closes right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while previous transaction in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_pay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_FOUND |-> o_m_tdata[43:12] == '0)
        else $error("payload nonzero on non-found result");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_FULL || o_m_tuser == ST_MISS)
        |-> o_m_tdata[11:0] == '0)
        else $error("slot nonzero on full or miss result");

endmodule

bind multi_hash_flow_match_table mhft_chk u_mhft_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

@@ bench/flow_table_checker.sv @@
// flow_table_checker: watches the request and result streams of the flow match table,
// predicts every result and compares it field by field. Depends on mhft_pkg.
`timescale 1ns / 100ps

module flow_table_checker
    import mhft_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [REQ_W-1:0]       i_s_tuser,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  wire logic [STAT_W-1:0]      i_m_tuser,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_AW-1:0]      i_cfg_addr,
    input  wire logic [CFG_DW-1:0]      i_cfg_data,
    output int                          o_pending,
    output int                          o_errors
);
    localparam int POOL = 4096;
    localparam int TABLES = 4;
    localparam int PROBES = 1000;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [PAY_W-1:0]   payload;
    } t_result;

    logic [SEED_W-1:0] seed_q [SEED_NUM];
    logic              slot_used [POOL];
    logic [PAY_W-1:0]  slot_pay [POOL];
    logic              idx_used [TABLES][POOL];
    logic [SLOT_W-1:0] idx_slot [TABLES][POOL];
    logic [31:0]       scrambler;
    t_result           expected_results [$];

    function automatic logic [SLOT_W-1:0] table_hash(logic [SEED_W-1:0] seed,
                                                     logic [31:0] addr,
                                                     logic [15:0] port);
        logic [31:0] h;
        h = {20'd0, seed};
        h = (h << 2) ^ h ^ addr;
        h = (h << 2) ^ h ^ {16'd0, port};
        return h[SLOT_W-1:0];
    endfunction

    // Apply one request to the shadow table and return its result.
    function automatic t_result apply_request(logic [1:0] req, logic [31:0] addr,
                                              logic [15:0] port, logic [31:0] pay);
        t_result r;
        logic [SLOT_W-1:0] h [TABLES];
        logic [SLOT_W-1:0] pos, cand;
        logic hit, have, got;
        int votes;
        r = '{ST_MISS, '0, '0};
        if (req == REQ_RSVD) return r;
        for (int t = 0; t < TABLES; t++) h[t] = table_hash(seed_q[t], addr, port);
        if (req == REQ_INSERT) begin
            scrambler = (scrambler << 2) ^ scrambler ^ 32'd1;
            pos = h[0] ^ scrambler[SLOT_W-1:0];
            got = 1'b0;
            for (int k = 0; k <= PROBES; k++) begin
                if (!slot_used[pos]) begin
                    got = 1'b1;
                    break;
                end
                pos = pos + SLOT_W'(PROBE_STEP);
            end
            if (!got) return '{ST_FULL, '0, '0};
            slot_used[pos] = 1'b1;
            slot_pay[pos] = pay;
            for (int t = 0; t < TABLES; t++) begin
                idx_used[t][h[t]] = 1'b1;
                idx_slot[t][h[t]] = pos;
            end
            return '{ST_INSERTED, pos, '0};
        end
        // majority vote over non-empty index entries
        have = 1'b0;
        cand = '0;
        votes = 0;
        for (int t = 0; t < TABLES; t++) begin
            if (!idx_used[t][h[t]]) continue;
            if (have && idx_slot[t][h[t]] == cand) votes++;
            else if (votes == 0) begin
                votes = 1;
                cand = idx_slot[t][h[t]];
                have = 1'b1;
            end else votes--;
        end
        if (!have) return r;
        hit = slot_used[cand];
        if (hit) r = '{ST_FOUND, cand, slot_pay[cand]};
        if (req == REQ_REMOVE) begin
            for (int t = 0; t < TABLES; t++)
                if (idx_used[t][h[t]] && idx_slot[t][h[t]] == cand)
                    idx_used[t][h[t]] = 1'b0;
            slot_used[cand] = 1'b0;
        end
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result got_r, exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < SEED_NUM; i++) seed_q[i] <= '0;
            for (int i = 0; i < POOL; i++) begin
                slot_used[i] = 1'b0;
                slot_pay[i] = '0;
                for (int t = 0; t < TABLES; t++) idx_used[t][i] = 1'b0;
            end
            scrambler = SCRAMBLER_RESET;
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we && i_cfg_addr[CFG_AW-1:2] < SEED_NUM)
                seed_q[i_cfg_addr[CFG_AW-1:2]] <= i_cfg_data[SEED_W-1:0];
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(apply_request(i_s_tuser, i_s_tdata[31:0],
                    i_s_tdata[47:32], i_s_tdata[79:48]));
            if (i_m_tvalid && i_m_tready) begin
                got_r = '{t_status'(i_m_tuser), i_m_tdata[11:0], i_m_tdata[43:12]};
                if (expected_results.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", got_r);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r !== exp_r || i_m_tdata[47:44] !== 4'd0) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %p actual %p", exp_r, got_r);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ bench/tb.sv @@
// tb: stimulus and verdict for multi_hash_flow_match_table; flow_table_checker
// does prediction and comparison. Depends on mhft_pkg and the block.
`timescale 1ns / 100ps

module tb;
    import mhft_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid, s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]       s_tuser;
    logic                   m_tvalid, m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]      m_tuser;
    logic                   psel, penable, pwrite, pready;
    logic [CFG_AW-1:0]      paddr;
    logic [CFG_DW-1:0]      pwdata, prdata;
    int                     pending, errors;

    // sender / receiver idle rates, percent
    int send_idle, recv_idle;

    // keys recently inserted, reused so searches actually hit
    logic [47:0] flow_keys [$];

    multi_hash_flow_match_table u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    flow_table_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .i_cfg_we(psel && penable && pwrite && pready),
        .i_cfg_addr(paddr), .i_cfg_data(pwdata),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: slow inserts walk up to 1001 probes.
    initial begin
        #400ms;
        $display("status: fail");
        $finish;
    end

    // Receiver stalls at random at the current rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // One transaction on the request stream; idle gaps before it at the sender rate.
    // tvalid stays up after the accept until the next request or an idle cycle.
    task automatic send_req(logic [1:0] req, logic [31:0] addr, logic [15:0] port,
                            logic [31:0] pay);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {pay, port, addr};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (req == REQ_INSERT) begin
            flow_keys.push_back({port, addr});
            if (flow_keys.size() > 64) void'(flow_keys.pop_front());
        end
    endtask

    // Wait for every result, then for the in-flight window of the longest insert.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    // APB write: setup then access cycle.
    task automatic seed_write(int idx, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CFG_AW'(idx * 4); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_req();
        logic [47:0] k;
        int sel;
        sel = $urandom_range(99);
        k = {16'($urandom()), $urandom()};
        if (flow_keys.size() != 0 && sel < 60 && sel >= 20)
            k = flow_keys[$urandom_range(flow_keys.size() - 1)];
        if (sel < 45) send_req(REQ_INSERT, k[31:0], k[47:32], $urandom());
        else if (sel < 70) send_req(REQ_SEARCH, k[31:0], k[47:32], $urandom());
        else if (sel < 97) send_req(REQ_REMOVE, k[31:0], k[47:32], $urandom());
        else send_req(REQ_RSVD, k[31:0], k[47:32], $urandom());
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        send_idle = 0; recv_idle = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset seeds, extremes of key fields, all operations.
        send_req(REQ_SEARCH, '0, '0, '0);                // empty table: no candidate
        send_req(REQ_INSERT, '0, '0, '0);
        send_req(REQ_INSERT, '1, '1, '1);
        send_req(REQ_SEARCH, '1, '1, '0);
        send_req(REQ_SEARCH, '0, '0, '1);
        send_req(REQ_REMOVE, '1, '1, '0);
        send_req(REQ_SEARCH, '1, '1, '0);                // removed
        send_req(REQ_RSVD, 32'hA5A5_5A5A, 16'h5A5A, 32'h1234_5678); // unused code
        send_req(REQ_INSERT, 32'h0A00_0001, 16'd80, 32'hDEAD_BEEF);
        send_req(REQ_INSERT, 32'h0A00_0001, 16'd80, 32'hCAFE_F00D); // same key twice
        send_req(REQ_REMOVE, 32'h0A00_0001, 16'd80, '0);
        send_req(REQ_SEARCH, 32'h0A00_0001, 16'd80, '0); // stale slot from overwrite
        send_req(REQ_REMOVE, 32'h0A00_0001, 16'd80, '0);
        // Pause until all results are back.
        drain();

        // Extreme seeds, then random seeds, then zeros; random traffic in each phase.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    seed_write(0, 32'hFFFF_FFFF); seed_write(1, 32'd0);
                    seed_write(2, 32'hFFF);       seed_write(3, 32'd1);
                    send_idle = 20; recv_idle = 88;
                end
                1: begin
                    for (int i = 0; i < SEED_NUM; i++) seed_write(i, $urandom());
                    send_idle = 88; recv_idle = 20;
                end
                default: begin
                    for (int i = 0; i < SEED_NUM; i++) seed_write(i, 32'd0);
                    send_idle = 0; recv_idle = 0;
                end
            endcase
            for (int n = 0; n < 480; n++) random_req();
            drain();
        end

        // Short burst of fresh inserts back to back, then mixed traffic.
        for (int n = 0; n < 40; n++)
            send_req(REQ_INSERT, $urandom(), 16'($urandom()), $urandom());
        for (int n = 0; n < 20; n++) random_req();
        drain();

        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
